>>> src/wrc_pkg.sv
// Shared types, constants and the control store of the word reverser.
// No dependencies; imported by wrc_stack and word_reverse_space_collapse_top.
package wrc_pkg;

    localparam int unsigned WRC_MAX_WORD = 32;
    localparam logic [7:0]  WRC_SPACE    = 8'd32;

    // Sequencer step addresses
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SEP   = 3'd1,
        S_POP   = 3'd2,
        S_DONE  = 3'd3,
        S_EMPTY = 3'd4
    } t_step;

    // Result source selected by a control word
    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_SEP   = 2'd1,
        E_POP   = 2'd2,
        E_EMPTY = 2'd3
    } t_emit;

    // Jump conditions
    typedef enum logic [1:0] {
        C_NEVER   = 2'd0,
        C_WORDEND = 2'd1,
        C_LAST    = 2'd2,
        C_MORE    = 2'd3
    } t_cond;

    typedef struct packed {
        logic  take;    // accept a request in this step
        t_emit emit;    // result to present
        logic  pop;     // read top of stack and shrink it
        logic  close;   // word finished: update flags, clear at string end
        t_cond cond_a;
        t_step tgt_a;
        t_cond cond_b;
        t_step tgt_b;
        t_step tgt_c;   // taken when neither condition holds
    } t_uword;

    // Stack port request between the top level and the stack memory
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       rd_en;
    } t_stack_req;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{take: 1'b0, emit: E_NONE, pop: 1'b0, close: 1'b0,
              cond_a: C_NEVER, tgt_a: S_IDLE, cond_b: C_NEVER, tgt_b: S_IDLE,
              tgt_c: S_IDLE};
        unique case (step)
            S_IDLE: begin
                w.take   = 1'b1;
                w.cond_a = C_WORDEND;
                w.tgt_a  = S_SEP;
                w.cond_b = C_LAST;
                w.tgt_b  = S_EMPTY;
                w.tgt_c  = S_IDLE;
            end
            S_SEP: begin
                w.emit  = E_SEP;
                w.pop   = 1'b1;
                w.tgt_c = S_POP;
            end
            S_POP: begin
                w.emit   = E_POP;
                w.pop    = 1'b1;
                w.cond_a = C_MORE;
                w.tgt_a  = S_POP;
                w.tgt_c  = S_DONE;
            end
            S_DONE: begin
                w.close = 1'b1;
                w.tgt_c = S_IDLE;
            end
            S_EMPTY: begin
                w.emit  = E_EMPTY;
                w.close = 1'b1;
                w.tgt_c = S_IDLE;
            end
            default: begin
                w.tgt_c = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> src/wrc_stack.sv
// Word stack: single-port-write, single-read memory with registered read data.
// Depends on wrc_pkg for the request struct.
module wrc_stack
    import wrc_pkg::*;
#(
    parameter int unsigned DEPTH = WRC_MAX_WORD,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  t_stack_req    i_req,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_req.wr_data;
        end
        // hold read data until the next read
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/word_reverse_space_collapse_top.sv
// Word reverser with space collapsing: microcoded sequencer, word stack, result register.
// Depends on wrc_pkg (types, control store) and wrc_stack (stack memory).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_ready  | i_in_char, i_in_last
//  result  | out       | o_valid / i_ready  | o_out_char, o_char_valid, o_out_end,
//          |           |                    | o_word_overflow
//
// Steps: a character that does not end a word is handled in the idle step alone. A word
// end runs the separator step, one pop step per stacked character and the close step;
// the stack's single registered read port feeds the pop loop, one character per pop.
// An empty string end runs the empty step.
// Reset: synchronous, active low; clears sequencer, counters, flags and the valid
// bit of the result register, but not its payload. The stack needs no clearing:
// only entries pushed in the current word are read back.
// Stalls: a full result register holds the sequencer in its emitting step;
// requests are taken only in the idle step, independent of the result side.
module word_reverse_space_collapse_top
    import wrc_pkg::*;
#(
    parameter int unsigned MAX_WORD = WRC_MAX_WORD,
    localparam int unsigned AW      = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
    localparam int unsigned LW      = $clog2(MAX_WORD + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_out_end,
    output logic       o_word_overflow
);

    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WORD);

    // sequencer and datapath state
    t_step         r_step,    n_step;
    logic [LW-1:0] r_len,     n_len;
    logic          r_emitted, n_emitted;
    logic          r_ovf,     n_ovf;
    logic          r_last,    n_last;

    // result register
    logic          r_o_valid, n_o_valid;
    logic [7:0]    r_o_char,  n_o_char;
    logic          r_o_cval,  n_o_cval;
    logic          r_o_end,   n_o_end;
    logic          r_o_ovf,   n_o_ovf;

    t_uword        uw;
    t_stack_req    stk_req;
    logic [AW-1:0] stk_wr_addr;
    logic [AW-1:0] stk_rd_addr;
    logic [7:0]    stk_rd_data;

    logic          is_space;
    logic          word_end;
    logic          emit_act;
    logic          slot_free;
    logic          advance;
    logic          cond_a_ok;
    logic          cond_b_ok;

    function automatic logic cond_eval(input t_cond c, input logic wend,
                                       input logic last, input logic more);
        logic r;
        r = 1'b0;
        unique case (c)
            C_NEVER:   r = 1'b0;
            C_WORDEND: r = wend;
            C_LAST:    r = last;
            C_MORE:    r = more;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // fetch the control word of the current step
    assign uw = uc_rom(r_step);

    assign is_space  = (i_in_char == WRC_SPACE);
    // word ends on a space over a non-empty stack, or at the final byte when
    // anything is stacked or is about to be pushed
    assign word_end  = (is_space && (r_len != '0)) ||
                       (i_in_last && (!is_space || (r_len != '0)));

    // separator only counts as a result once a word has gone out
    assign emit_act  = (uw.emit == E_POP) || (uw.emit == E_EMPTY) ||
                       ((uw.emit == E_SEP) && r_emitted);
    assign slot_free = !r_o_valid || i_ready;
    assign advance   = (!uw.take || i_valid) && (!emit_act || slot_free);

    assign cond_a_ok = cond_eval(uw.cond_a, word_end, i_in_last, r_len != '0);
    assign cond_b_ok = cond_eval(uw.cond_b, word_end, i_in_last, r_len != '0);

    // stack addressing: push at the length, pop from the length minus one
    assign stk_wr_addr     = r_len[AW-1:0];
    assign stk_rd_addr     = AW'(r_len - LW'(1));
    assign stk_req.wr_en   = uw.take && i_valid && !is_space && (r_len < LEN_MAX);
    assign stk_req.wr_data = i_in_char;
    assign stk_req.rd_en   = uw.pop && advance && (r_len != '0);

    always_comb begin
        n_step    = r_step;
        n_len     = r_len;
        n_emitted = r_emitted;
        n_ovf     = r_ovf;
        n_last    = r_last;
        n_o_valid = r_o_valid;
        n_o_char  = r_o_char;
        n_o_cval  = r_o_cval;
        n_o_end   = r_o_end;
        n_o_ovf   = r_o_ovf;

        // drop the presented result once taken
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        if (advance) begin
            // take a request: push, or flag the dropped character
            if (uw.take) begin
                n_last = i_in_last;
                if (!is_space) begin
                    if (r_len < LEN_MAX) begin
                        n_len = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end

            if (stk_req.rd_en) begin
                n_len = r_len - LW'(1);
            end

            if (emit_act) begin
                n_o_valid = 1'b1;
                case (uw.emit)
                    E_SEP: begin
                        n_o_char = WRC_SPACE;
                        n_o_cval = 1'b1;
                        n_o_end  = 1'b0;
                        n_o_ovf  = r_ovf;
                    end
                    E_POP: begin
                        n_o_char = stk_rd_data;
                        n_o_cval = 1'b1;
                        n_o_end  = r_last && (r_len == '0);
                        n_o_ovf  = r_ovf;
                    end
                    default: begin
                        n_o_char = '0;
                        n_o_cval = 1'b0;
                        n_o_end  = 1'b1;
                        n_o_ovf  = 1'b0;
                    end
                endcase
            end

            // close the word; reset string state after the final byte
            if (uw.close) begin
                n_emitted = !r_last;
                n_ovf     = 1'b0;
                if (r_last) begin
                    n_len = '0;
                end
            end

            if (cond_a_ok) begin
                n_step = uw.tgt_a;
            end else if (cond_b_ok) begin
                n_step = uw.tgt_b;
            end else begin
                n_step = uw.tgt_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= S_IDLE;
            r_len     <= '0;
            r_emitted <= 1'b0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_len     <= n_len;
            r_emitted <= n_emitted;
            r_ovf     <= n_ovf;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_o_char <= n_o_char;
        r_o_cval <= n_o_cval;
        r_o_end  <= n_o_end;
        r_o_ovf  <= n_o_ovf;
    end

    wrc_stack #(
        .DEPTH(MAX_WORD)
    ) u_stack (
        .i_clk     (i_clk),
        .i_req     (stk_req),
        .i_wr_addr (stk_wr_addr),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    assign o_ready         = uw.take;
    assign o_valid         = r_o_valid;
    assign o_out_char      = r_o_char;
    assign o_char_valid    = r_o_cval;
    assign o_out_end       = r_o_end;
    assign o_word_overflow = r_o_ovf;

    // stack length never passes its depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("word stack length beyond depth");

    // an empty marker is always the string end and carries nothing
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_out_end && (o_out_char == '0) && !o_word_overflow))
        else $error("malformed empty end marker");

    // while collecting, a lost character implies a full stack
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == S_IDLE) && r_ovf) |-> (r_len == LEN_MAX))
        else $error("overflow flagged with room on the stack");

endmodule
